// File: rtl/i2c_mbe_pkg.sv
package i2c_mbe_pkg;

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_TICKS_PER_UNIT = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_ACK_POLL_LIMIT = 1'd1;

  localparam logic [15:0] TICKS_PER_UNIT_RST = 16'd100;
  localparam logic [7:0]  ACK_POLL_LIMIT_RST = 8'd250;

  // Command codes.
  localparam logic [2:0] OP_TICK  = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_STOP  = 3'd2;
  localparam logic [2:0] OP_WRITE = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;

  // Sequencer phases.
  localparam logic [4:0] PH_IDLE = 5'd0;
  localparam logic [4:0] PH_ST1  = 5'd1;
  localparam logic [4:0] PH_ST2  = 5'd2;
  localparam logic [4:0] PH_SP1  = 5'd3;
  localparam logic [4:0] PH_SP2  = 5'd4;
  localparam logic [4:0] PH_WL   = 5'd5;
  localparam logic [4:0] PH_WH   = 5'd6;
  localparam logic [4:0] PH_WA   = 5'd7;
  localparam logic [4:0] PH_AL   = 5'd8;
  localparam logic [4:0] PH_AH   = 5'd9;
  localparam logic [4:0] PH_AP   = 5'd10;
  localparam logic [4:0] PH_RL   = 5'd11;
  localparam logic [4:0] PH_RH   = 5'd12;
  localparam logic [4:0] PH_KL   = 5'd13;
  localparam logic [4:0] PH_KH   = 5'd14;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_sample;
  } in_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       ready_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_error;
  } out_t;

  typedef struct packed {
    logic [15:0] ticks_per_unit;
    logic [7:0]  ack_poll_limit;
  } cfg_t;

endpackage

// File: rtl/i2c_mbe_core.sv
module i2c_mbe_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  i2c_mbe_pkg::in_t  in_i,
  input  i2c_mbe_pkg::cfg_t cfg_i,
  output i2c_mbe_pkg::out_t res_o
);
  import i2c_mbe_pkg::*;

  logic [4:0]  phase_q, phase_d;
  logic [3:0]  bit_q, bit_d;
  logic [7:0]  shift_q, shift_d;
  logic [15:0] tick_q, tick_d;
  logic [2:0]  unit_q, unit_d;
  logic [7:0]  poll_q, poll_d;
  logic        ack_q, ack_d;
  logic        scl_q, scl_d;
  logic        sda_q, sda_d;
  logic        drv_q, drv_d;
  logic [7:0]  rx_q, rx_d;
  logic        err_q, err_d;
  logic        done;

  logic [15:0] ticks_eff;
  logic [16:0] tick_inc;
  logic [2:0]  unit_inc;
  logic [2:0]  units;
  logic        tick_hit;
  logic        seg_end;
  logic        timed;
  logic [3:0]  bit_inc;

  assign ticks_eff = (cfg_i.ticks_per_unit == '0) ? 16'd1 : cfg_i.ticks_per_unit;
  assign tick_inc  = {1'b0, tick_q} + 17'd1;
  assign unit_inc  = unit_q + 3'd1;
  assign tick_hit  = tick_inc >= {1'b0, ticks_eff};
  assign bit_inc   = bit_q + 4'd1;

  // Segment length in delay units for each timed phase.
  always_comb begin
    case (phase_q)
      PH_ST1, PH_ST2, PH_SP1, PH_SP2: units = 3'd4;
      PH_AL, PH_AH, PH_RH:            units = 3'd1;
      default:                        units = 3'd2;
    endcase
  end

  assign timed   = !(phase_q inside {PH_IDLE, PH_AP});
  assign seg_end = tick_hit && (unit_inc >= units);

  always_comb begin
    phase_d = phase_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    tick_d  = tick_q;
    unit_d  = unit_q;
    poll_d  = poll_q;
    ack_d   = ack_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    drv_d   = drv_q;
    rx_d    = rx_q;
    err_d   = err_q;
    done    = 1'b0;

    if (timed) begin
      if (tick_hit) begin
        tick_d = '0;
        unit_d = seg_end ? 3'd0 : unit_inc;
      end else begin
        tick_d = tick_inc[15:0];
      end
    end

    case (phase_q)
      PH_IDLE: begin
        case (in_i.opcode)
          OP_START: begin
            {scl_d, sda_d, drv_d} = 3'b111;
            phase_d = PH_ST1;
            tick_d  = '0;
            unit_d  = '0;
          end
          OP_STOP: begin
            {scl_d, sda_d, drv_d} = 3'b001;
            phase_d = PH_SP1;
            tick_d  = '0;
            unit_d  = '0;
          end
          OP_WRITE: begin
            err_d   = 1'b0;
            bit_d   = '0;
            scl_d   = 1'b0;
            sda_d   = in_i.tx_byte[7];
            drv_d   = 1'b1;
            shift_d = {in_i.tx_byte[6:0], 1'b0};
            phase_d = PH_WL;
            tick_d  = '0;
            unit_d  = '0;
          end
          OP_READ: begin
            bit_d   = '0;
            shift_d = '0;
            ack_d   = in_i.send_ack;
            scl_d   = 1'b0;
            drv_d   = 1'b0;
            phase_d = PH_RL;
            tick_d  = '0;
            unit_d  = '0;
          end
          default: begin
          end
        endcase
      end
      PH_ST1: if (seg_end) begin
        sda_d   = 1'b0;
        phase_d = PH_ST2;
      end
      PH_ST2: if (seg_end) begin
        scl_d   = 1'b0;
        phase_d = PH_IDLE;
        done    = 1'b1;
      end
      PH_SP1: if (seg_end) begin
        {scl_d, sda_d, drv_d} = 3'b111;
        phase_d = PH_SP2;
      end
      PH_SP2: if (seg_end) begin
        phase_d = PH_IDLE;
        done    = 1'b1;
      end
      PH_WL: if (seg_end) begin
        scl_d   = 1'b1;
        phase_d = PH_WH;
      end
      PH_WH: if (seg_end) begin
        scl_d   = 1'b0;
        phase_d = PH_WA;
      end
      PH_WA: if (seg_end) begin
        bit_d = bit_inc;
        if (bit_inc < 4'd8) begin
          sda_d   = shift_q[7];
          shift_d = {shift_q[6:0], 1'b0};
          phase_d = PH_WL;
        end else begin
          {scl_d, sda_d, drv_d} = 3'b010;
          phase_d = PH_AL;
        end
      end
      PH_AL: if (seg_end) begin
        scl_d   = 1'b1;
        phase_d = PH_AH;
      end
      PH_AH: if (seg_end) begin
        poll_d  = '0;
        phase_d = PH_AP;
      end
      PH_AP: begin
        if (!in_i.sda_sample) begin
          scl_d   = 1'b0;
          phase_d = PH_IDLE;
          done    = 1'b1;
        end else if (poll_q >= cfg_i.ack_poll_limit) begin
          // No ACK in time: release the bus with a stop and flag it.
          err_d   = 1'b1;
          {scl_d, sda_d, drv_d} = 3'b001;
          phase_d = PH_SP1;
          tick_d  = '0;
          unit_d  = '0;
        end else begin
          poll_d = poll_q + 8'd1;
        end
      end
      PH_RL: if (seg_end) begin
        scl_d   = 1'b1;
        shift_d = {shift_q[6:0], in_i.sda_sample};
        phase_d = PH_RH;
      end
      PH_RH: if (seg_end) begin
        bit_d = bit_inc;
        if (bit_inc < 4'd8) begin
          scl_d   = 1'b0;
          phase_d = PH_RL;
        end else begin
          scl_d   = 1'b0;
          sda_d   = !ack_q;
          drv_d   = 1'b1;
          phase_d = PH_KL;
        end
      end
      PH_KL: if (seg_end) begin
        scl_d   = 1'b1;
        phase_d = PH_KH;
      end
      PH_KH: if (seg_end) begin
        scl_d   = 1'b0;
        rx_d    = shift_q;
        phase_d = PH_IDLE;
        done    = 1'b1;
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      bit_q   <= '0;
      shift_q <= '0;
      tick_q  <= '0;
      unit_q  <= '0;
      poll_q  <= '0;
      ack_q   <= 1'b0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
      drv_q   <= 1'b1;
      rx_q    <= '0;
      err_q   <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      tick_q  <= tick_d;
      unit_q  <= unit_d;
      poll_q  <= poll_d;
      ack_q   <= ack_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
      drv_q   <= drv_d;
      rx_q    <= rx_d;
      err_q   <= err_d;
    end
  end

  assign res_o.scl_level = scl_d;
  assign res_o.sda_level = sda_d;
  assign res_o.sda_drive = drv_d;
  assign res_o.ready_res = (phase_d == PH_IDLE);
  assign res_o.done_res  = done;
  assign res_o.rx_byte   = rx_d;
  assign res_o.ack_error = err_d;

`ifndef NO_ASSERTIONS
  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    unit_q < 3'd4)
    else $error("unit counter out of range");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.done_res |-> res_o.ready_res)
    else $error("command completed without returning to idle");

  a_write_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && phase_q == PH_IDLE && in_i.opcode == OP_WRITE)
    |=> (phase_q == PH_WL && !err_q && drv_q && !scl_q))
    else $error("write command did not start the first data bit");
`endif

endmodule

// File: rtl/i2c_master_byte_engine.sv
// Channel  Direction  Handshake                    Payload
// in       input      in_valid_i / in_ready_o      in_data_i  (one bus tick, optional command)
// out      output     out_valid_o / out_ready_i    out_data_o (line levels and status)
// cfg      input      cfg_we_i                     cfg_idx_i, cfg_wdata_i
//
// Each accepted word is one bus tick and yields one result word in the following cycle.
// A new word is taken every cycle while the sink is not stalling; the single output
// register holds a result while the sink stalls, and input is held off only while
// that register is full and not being taken. Reset puts the bus at SCL high, SDA high
// and driven, with ticks_per_unit 100 and ack_poll_limit 250.
module i2c_master_byte_engine (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  i2c_mbe_pkg::in_t                    in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output i2c_mbe_pkg::out_t                   out_data_o,
  input  logic                                cfg_we_i,
  input  logic [i2c_mbe_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [i2c_mbe_pkg::CfgDataW-1:0]    cfg_wdata_i
);
  import i2c_mbe_pkg::*;

  cfg_t cfg_q;
  out_t res;
  out_t out_q;
  logic out_valid_q;
  logic accept;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ticks_per_unit <= TICKS_PER_UNIT_RST;
      cfg_q.ack_poll_limit <= ACK_POLL_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TICKS_PER_UNIT: cfg_q.ticks_per_unit <= cfg_wdata_i;
        CFG_ACK_POLL_LIMIT: cfg_q.ack_poll_limit <= cfg_wdata_i[7:0];
        default: begin
        end
      endcase
    end
  end

  i2c_mbe_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (accept),
    .in_i   (in_data_i),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("accepted word produced no result");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with the output register empty");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("result word changed while stalled");
`endif

endmodule
